/* sv/cel_pkg.sv */
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types, character codes and item helpers for the condition
// expression lexer.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int CEL_MAX_ITEMS   = 4;
  localparam int CEL_QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    K_STRING = 4'd0,
    K_REGEX  = 4'd1,
    K_LPAREN = 4'd2,
    K_RPAREN = 4'd3,
    K_EQ     = 4'd4,
    K_NE     = 4'd5,
    K_NOT    = 4'd6,
    K_OR     = 4'd7,
    K_AND    = 4'd8,
    K_GE     = 4'd9,
    K_GT     = 4'd10,
    K_LE     = 4'd11,
    K_LT     = 4'd12,
    K_ACCESS = 4'd13,
    K_NONE   = 4'd14
  } kind_t;

  typedef enum logic [1:0] {
    M_IDLE   = 2'd0,
    M_PEND   = 2'd1,
    M_UNQ    = 2'd2,
    M_QUOTED = 2'd3
  } mode_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_done;
    logic       unclosed;
    logic       end_of_text;
  } item_t;

  // One input character's worth of result items, items[0] first.
  typedef struct packed {
    item_t [CEL_MAX_ITEMS-1:0] items;
    logic  [2:0]               count;
  } bundle_t;

  localparam int CEL_BUNDLE_W = $bits(bundle_t);

  function automatic item_t mk_byte(kind_t kind, logic [7:0] c);
    item_t it;
    it.kind        = kind;
    it.value_byte  = c;
    it.has_byte    = 1'b1;
    it.token_done  = 1'b0;
    it.unclosed    = 1'b0;
    it.end_of_text = 1'b0;
    return it;
  endfunction

  function automatic item_t mk_close(kind_t kind, logic uncl);
    item_t it;
    it.kind        = kind;
    it.value_byte  = 8'h00;
    it.has_byte    = 1'b0;
    it.token_done  = 1'b1;
    it.unclosed    = uncl;
    it.end_of_text = 1'b0;
    return it;
  endfunction

  function automatic item_t mk_end();
    item_t it;
    it.kind        = K_NONE;
    it.value_byte  = 8'h00;
    it.has_byte    = 1'b0;
    it.token_done  = 1'b0;
    it.unclosed    = 1'b0;
    it.end_of_text = 1'b1;
    return it;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* sv/cel_queue.sv */
// ----------------------------------------------------------------------------
// cel_queue
// Small register FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module cel_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/cel_front.sv */
// ----------------------------------------------------------------------------
// cel_front
// Lexer state machine: classify one character per transaction and build the
// bundle of result items it causes.
// ----------------------------------------------------------------------------
module cel_front
  import cel_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       final_char,
  output logic       push,
  output bundle_t    bundle
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_v_r, held_v_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] delim_r, delim_nxt;
  logic       pwa_r, pwa_nxt;

  // One spare slot: an operator flushed at end of text after a string can
  // push the end marker past the bundle, where it is dropped.
  item_t [CEL_MAX_ITEMS:0] it;
  logic [2:0] n;
  logic       dispatch;
  logic       unq_rest;
  kind_t      qkind;

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    esc_nxt    = esc_r;
    delim_nxt  = delim_r;
    pwa_nxt    = pwa_r;
    it         = '0;
    n          = 3'd0;
    dispatch   = 1'b0;
    unq_rest   = 1'b0;
    qkind      = (delim_r == CH_SLASH) ? K_REGEX : K_STRING;

    case (mode_r)
      M_PEND: begin
        held_v_nxt = 1'b0;
        held_nxt   = 8'h00;
        mode_nxt   = M_IDLE;
        case (held_r)
          CH_EQ: begin
            it[n] = mk_close(K_EQ, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
            dispatch = (ch != CH_EQ);
          end
          CH_BANG, CH_GT, CH_LT: begin
            if (ch == CH_EQ) begin
              it[n] = mk_close((held_r == CH_BANG) ? K_NE :
                               (held_r == CH_GT) ? K_GE : K_LE, 1'b0);
            end else begin
              it[n] = mk_close((held_r == CH_BANG) ? K_NOT :
                               (held_r == CH_GT) ? K_GT : K_LT, 1'b0);
              dispatch = 1'b1;
            end
            n = n + 3'd1; pwa_nxt = 1'b0;
          end
          CH_PIPE, CH_AMP: begin
            if (ch == held_r) begin
              it[n] = mk_close((held_r == CH_PIPE) ? K_OR : K_AND, 1'b0);
              n = n + 3'd1; pwa_nxt = 1'b0;
            end else begin
              it[n] = mk_byte(K_STRING, held_r); n = n + 3'd1;
              unq_rest = 1'b1;
            end
          end
          CH_DASH: begin
            if (ch == CH_UPPER_A) begin
              it[n] = mk_close(K_ACCESS, 1'b0); n = n + 3'd1; pwa_nxt = 1'b1;
            end else begin
              it[n] = mk_byte(K_STRING, held_r); n = n + 3'd1;
              unq_rest = 1'b1;
            end
          end
          default: begin
            dispatch = 1'b1;
          end
        endcase
      end
      M_UNQ: begin
        if (esc_r) begin
          it[n] = mk_byte(K_STRING, ch); n = n + 3'd1;
          esc_nxt = 1'b0;
        end else if (held_v_r) begin
          held_v_nxt = 1'b0;
          held_nxt   = 8'h00;
          if (ch == held_r) begin
            // doubled | or & ends the string and forms an operator
            it[n] = mk_close(K_STRING, 1'b0); n = n + 3'd1;
            it[n] = mk_close((held_r == CH_PIPE) ? K_OR : K_AND, 1'b0);
            n = n + 3'd1; pwa_nxt = 1'b0;
            mode_nxt = M_IDLE;
          end else begin
            it[n] = mk_byte(K_STRING, held_r); n = n + 3'd1;
            unq_rest = 1'b1;
          end
        end else begin
          unq_rest = 1'b1;
        end
      end
      M_QUOTED: begin
        if (esc_r) begin
          it[n] = mk_byte(qkind, ch); n = n + 3'd1;
          esc_nxt = 1'b0;
        end else if (ch == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (ch == delim_r) begin
          it[n] = mk_close(qkind, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
          mode_nxt  = M_IDLE;
          delim_nxt = 8'h00;
        end else begin
          it[n] = mk_byte(qkind, ch); n = n + 3'd1;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        dispatch = 1'b1;
      end
    endcase

    // remainder of the unquoted-string rule, nothing held and no escape
    if (unq_rest) begin
      mode_nxt = M_UNQ;
      if (ch == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (is_blank(ch)) begin
        it[n] = mk_close(K_STRING, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
        mode_nxt = M_IDLE;
      end else if ((ch == CH_LPAREN) || (ch == CH_RPAREN) || (ch == CH_EQ) ||
                   (ch == CH_BANG) || (ch == CH_LT) || (ch == CH_GT)) begin
        it[n] = mk_close(K_STRING, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
        mode_nxt = M_IDLE;
        dispatch = 1'b1;
      end else if ((ch == CH_PIPE) || (ch == CH_AMP)) begin
        held_nxt   = ch;
        held_v_nxt = 1'b1;
      end else begin
        it[n] = mk_byte(K_STRING, ch); n = n + 3'd1;
      end
    end

    // start of a new token
    if (dispatch && !is_blank(ch)) begin
      case (ch)
        CH_LPAREN: begin
          it[n] = mk_close(K_LPAREN, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
        end
        CH_RPAREN: begin
          it[n] = mk_close(K_RPAREN, 1'b0); n = n + 3'd1; pwa_nxt = 1'b0;
        end
        CH_EQ, CH_BANG, CH_GT, CH_LT, CH_PIPE, CH_AMP, CH_DASH: begin
          mode_nxt   = M_PEND;
          held_nxt   = ch;
          held_v_nxt = 1'b1;
        end
        CH_QUOTE: begin
          mode_nxt  = M_QUOTED;
          delim_nxt = ch;
          esc_nxt   = 1'b0;
        end
        CH_SLASH: begin
          if (pwa_nxt) begin
            it[n] = mk_byte(K_STRING, ch); n = n + 3'd1;
            mode_nxt = M_UNQ;
          end else begin
            mode_nxt  = M_QUOTED;
            delim_nxt = ch;
            esc_nxt   = 1'b0;
          end
        end
        default: begin
          mode_nxt = M_UNQ;
          if (ch == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else begin
            it[n] = mk_byte(K_STRING, ch); n = n + 3'd1;
          end
        end
      endcase
    end

    // end of text: flush the open token, mark the end, return to reset state
    if (final_char) begin
      case (mode_nxt)
        M_PEND: begin
          case (held_nxt)
            CH_EQ:   begin it[n] = mk_close(K_EQ, 1'b0);  n = n + 3'd1; end
            CH_BANG: begin it[n] = mk_close(K_NOT, 1'b0); n = n + 3'd1; end
            CH_GT:   begin it[n] = mk_close(K_GT, 1'b0);  n = n + 3'd1; end
            CH_LT:   begin it[n] = mk_close(K_LT, 1'b0);  n = n + 3'd1; end
            default: begin
              it[n] = mk_byte(K_STRING, held_nxt); n = n + 3'd1;
              it[n] = mk_close(K_STRING, 1'b0);    n = n + 3'd1;
            end
          endcase
        end
        M_UNQ: begin
          if (held_v_nxt) begin
            it[n] = mk_byte(K_STRING, held_nxt); n = n + 3'd1;
          end
          if (esc_nxt) begin
            it[n] = mk_byte(K_STRING, CH_BSLASH); n = n + 3'd1;
          end
          it[n] = mk_close(K_STRING, 1'b0); n = n + 3'd1;
        end
        M_QUOTED: begin
          it[n] = mk_close((delim_nxt == CH_SLASH) ? K_REGEX : K_STRING, 1'b1);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      it[n] = mk_end(); n = n + 3'd1;
      mode_nxt   = M_IDLE;
      held_nxt   = 8'h00;
      held_v_nxt = 1'b0;
      esc_nxt    = 1'b0;
      delim_nxt  = 8'h00;
      pwa_nxt    = 1'b0;
    end
  end

  // Keep at most CEL_MAX_ITEMS items; drop anything beyond.
  assign bundle.items = it[CEL_MAX_ITEMS-1:0];
  assign bundle.count = (n > 3'(CEL_MAX_ITEMS)) ? 3'(CEL_MAX_ITEMS) : n;
  assign push         = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= 8'h00;
      held_v_r <= 1'b0;
      esc_r    <= 1'b0;
      delim_r  <= 8'h00;
      pwa_r    <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      esc_r    <= esc_nxt;
      delim_r  <= delim_nxt;
      pwa_r    <= pwa_nxt;
    end
  end

endmodule

/* sv/cel_back.sv */
// ----------------------------------------------------------------------------
// cel_back
// Serialize the queued bundles into single result items behind an output
// register.
// ----------------------------------------------------------------------------
module cel_back
  import cel_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  bundle_t head,
  input  logic    head_valid,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output item_t   out_item,
  output logic    out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  item_t      item_r, item_nxt;
  logic       last_r, last_nxt;
  logic       load, at_last;

  assign load    = head_valid && (!ov_r || out_ready);
  assign at_last = ({1'b0, idx_r} == (head.count - 3'd1));
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    item_nxt = item_r;
    last_nxt = last_r;
    if (load) begin
      ov_nxt   = 1'b1;
      item_nxt = head.items[idx_r];
      last_nxt = at_last;
      idx_nxt  = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = item_r;
  assign out_last  = last_r;

endmodule

/* sv/condition_expression_lexer_unit.sv */
// ----------------------------------------------------------------------------
// condition_expression_lexer_unit
// Items pass through the bundle queue (it absorbs bursts) and the output register.
// Throughput: one character per cycle while each causes at most one item and
//   out_tready is high; a character with k items needs k transfers (k up to 4).
// The output register drains one item per cycle while out_tready is high.
// Reset (rst_n low, synchronous): lexer idle, queue and output register empty.
// ----------------------------------------------------------------------------
module condition_expression_lexer_unit
  import cel_pkg::*;
#(
  parameter int QUEUE_DEPTH = CEL_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // final_char
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value_byte
  output logic [7:0] out_tuser,  // [3:0] kind, [4] has_byte, [5] token_done,
                                 // [6] unclosed, [7] end_of_text
  output logic       out_tlast   // run_last
);

  logic    in_accept;
  logic    push;
  bundle_t push_bundle;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic [CEL_BUNDLE_W-1:0] q_head_bits;
  bundle_t q_head;
  item_t   o_item;

  // Accept a transaction whenever the queue has room for its bundle.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  // Front: classify the character and build its result bundle.
  cel_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .ch         (in_tdata),
    .final_char (in_tlast),
    .push       (push),
    .bundle     (push_bundle)
  );

  // Hold bundles so the front keeps taking characters while the back drains.
  cel_queue #(
    .WIDTH (CEL_BUNDLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_bundle),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head_bits),
    .empty     (q_empty)
  );

  assign q_head = bundle_t'(q_head_bits);

  // Back: advance through the head bundle one item per output transaction.
  cel_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (o_item),
    .out_last   (out_tlast)
  );

  // Pack item fields onto the stream ports.
  assign out_tdata = o_item.value_byte;
  assign out_tuser = {o_item.end_of_text, o_item.unclosed, o_item.token_done,
                      o_item.has_byte, o_item.kind};

endmodule

/* tb/sv/cel_token_checker.sv */
// ----------------------------------------------------------------------------
// cel_token_checker
// Watches both streams of the condition expression lexer, tokenizes every
// accepted character on its own, and compares each result transaction with
// the oldest token item still due.
// ----------------------------------------------------------------------------
module cel_token_checker
  import cel_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [7:0] out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending_items,
  output int         items_checked,
  output int         tokens_checked
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_done;
    logic       unclosed;
    logic       end_of_text;
    logic       run_last;
  } token_item_t;

  // lexer state
  mode_t      lex_mode;
  logic [7:0] held_ch;
  logic       held_ok;
  logic       esc_pending;
  logic [7:0] close_ch;
  logic       after_access;

  token_item_t step_items[$];
  token_item_t due_token_items[$];
  int          errors;
  int          n_items;
  int          n_tokens;

  function automatic logic is_space_char(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic void add_item(kind_t k, logic [7:0] b, logic has, logic done,
                                   logic uncl, logic eot);
    token_item_t it;
    if (step_items.size() >= CEL_MAX_ITEMS) return;
    it = '{k, b, has, done, uncl, eot, 1'b0};
    step_items.push_back(it);
  endfunction

  function automatic void push_byte(kind_t k, logic [7:0] c);
    add_item(k, c, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void finish_token(kind_t k, logic uncl);
    add_item(k, 8'h00, 1'b0, 1'b1, uncl, 1'b0);
    after_access = (k == K_ACCESS);
  endfunction

  function automatic void reset_lexer();
    lex_mode     = M_IDLE;
    held_ch      = 8'h00;
    held_ok      = 1'b0;
    esc_pending  = 1'b0;
    close_ch     = 8'h00;
    after_access = 1'b0;
  endfunction

  function automatic void start_token(logic [7:0] c);
    if (is_space_char(c)) return;
    case (c)
      CH_LPAREN: finish_token(K_LPAREN, 1'b0);
      CH_RPAREN: finish_token(K_RPAREN, 1'b0);
      CH_EQ, CH_BANG, CH_GT, CH_LT, CH_PIPE, CH_AMP, CH_DASH: begin
        lex_mode = M_PEND;
        held_ch  = c;
        held_ok  = 1'b1;
      end
      CH_QUOTE: begin
        lex_mode    = M_QUOTED;
        close_ch    = c;
        esc_pending = 1'b0;
      end
      CH_SLASH: begin
        // a slash right after -A is plain text, not a regex
        if (after_access) begin
          push_byte(K_STRING, c);
          lex_mode = M_UNQ;
        end else begin
          lex_mode    = M_QUOTED;
          close_ch    = c;
          esc_pending = 1'b0;
        end
      end
      default: begin
        lex_mode = M_UNQ;
        continue_word(c);
      end
    endcase
  endfunction

  function automatic void continue_word(logic [7:0] c);
    logic [7:0] h;
    if (esc_pending) begin
      push_byte(K_STRING, c);
      esc_pending = 1'b0;
      return;
    end
    if (held_ok) begin
      h       = held_ch;
      held_ok = 1'b0;
      held_ch = 8'h00;
      if (c == h) begin
        finish_token(K_STRING, 1'b0);
        finish_token((h == CH_PIPE) ? K_OR : K_AND, 1'b0);
        lex_mode = M_IDLE;
        return;
      end
      push_byte(K_STRING, h);
    end
    if (c == CH_BSLASH) begin
      esc_pending = 1'b1;
      return;
    end
    if (is_space_char(c)) begin
      finish_token(K_STRING, 1'b0);
      lex_mode = M_IDLE;
      return;
    end
    case (c)
      CH_LPAREN, CH_RPAREN, CH_EQ, CH_BANG, CH_LT, CH_GT: begin
        finish_token(K_STRING, 1'b0);
        lex_mode = M_IDLE;
        start_token(c);
      end
      CH_PIPE, CH_AMP: begin
        held_ch = c;
        held_ok = 1'b1;
      end
      default: push_byte(K_STRING, c);
    endcase
  endfunction

  function automatic void resolve_pending(logic [7:0] c);
    logic [7:0] h;
    h        = held_ch;
    held_ok  = 1'b0;
    held_ch  = 8'h00;
    lex_mode = M_IDLE;
    case (h)
      CH_EQ: begin
        finish_token(K_EQ, 1'b0);
        if (c != CH_EQ) start_token(c);
      end
      CH_BANG: begin
        if (c == CH_EQ) finish_token(K_NE, 1'b0);
        else begin
          finish_token(K_NOT, 1'b0);
          start_token(c);
        end
      end
      CH_GT: begin
        if (c == CH_EQ) finish_token(K_GE, 1'b0);
        else begin
          finish_token(K_GT, 1'b0);
          start_token(c);
        end
      end
      CH_LT: begin
        if (c == CH_EQ) finish_token(K_LE, 1'b0);
        else begin
          finish_token(K_LT, 1'b0);
          start_token(c);
        end
      end
      CH_PIPE, CH_AMP: begin
        if (c == h) finish_token((h == CH_PIPE) ? K_OR : K_AND, 1'b0);
        else begin
          push_byte(K_STRING, h);
          lex_mode = M_UNQ;
          continue_word(c);
        end
      end
      CH_DASH: begin
        if (c == CH_UPPER_A) finish_token(K_ACCESS, 1'b0);
        else begin
          push_byte(K_STRING, h);
          lex_mode = M_UNQ;
          continue_word(c);
        end
      end
      default: start_token(c);
    endcase
  endfunction

  function automatic void continue_quoted(logic [7:0] c);
    kind_t k;
    k = (close_ch == CH_SLASH) ? K_REGEX : K_STRING;
    if (esc_pending) begin
      push_byte(k, c);
      esc_pending = 1'b0;
      return;
    end
    if (c == CH_BSLASH) begin
      esc_pending = 1'b1;
      return;
    end
    if (c == close_ch) begin
      finish_token(k, 1'b0);
      lex_mode = M_IDLE;
      close_ch = 8'h00;
      return;
    end
    push_byte(k, c);
  endfunction

  function automatic void flush_at_end();
    case (lex_mode)
      M_PEND: begin
        case (held_ch)
          CH_EQ:   finish_token(K_EQ, 1'b0);
          CH_BANG: finish_token(K_NOT, 1'b0);
          CH_GT:   finish_token(K_GT, 1'b0);
          CH_LT:   finish_token(K_LT, 1'b0);
          default: begin
            push_byte(K_STRING, held_ch);
            finish_token(K_STRING, 1'b0);
          end
        endcase
      end
      M_UNQ: begin
        if (held_ok) push_byte(K_STRING, held_ch);
        if (esc_pending) push_byte(K_STRING, CH_BSLASH);
        finish_token(K_STRING, 1'b0);
      end
      M_QUOTED: finish_token((close_ch == CH_SLASH) ? K_REGEX : K_STRING, 1'b1);
      default: ;
    endcase
    add_item(K_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
  endfunction

  // Tokenize one accepted character and queue the items it must produce.
  function automatic void tokenize_char(logic [7:0] c, logic last_char);
    token_item_t tail;
    step_items.delete();
    case (lex_mode)
      M_PEND:   resolve_pending(c);
      M_UNQ:    continue_word(c);
      M_QUOTED: continue_quoted(c);
      default: begin
        lex_mode = M_IDLE;
        start_token(c);
      end
    endcase
    if (last_char) begin
      flush_at_end();
      reset_lexer();
    end
    if (step_items.size() > 0) begin
      tail          = step_items.pop_back();
      tail.run_last = 1'b1;
      step_items.push_back(tail);
    end
    foreach (step_items[i]) due_token_items.push_back(step_items[i]);
  endfunction

  function automatic string item_text(token_item_t it);
    return $sformatf("kind=%0d byte=%02h has=%b done=%b uncl=%b eot=%b last=%b",
                     it.kind, it.value_byte, it.has_byte, it.token_done,
                     it.unclosed, it.end_of_text, it.run_last);
  endfunction

  function automatic void check_result();
    token_item_t got;
    token_item_t want;
    got.kind        = kind_t'(out_tuser[3:0]);
    got.value_byte  = out_tdata;
    got.has_byte    = out_tuser[4];
    got.token_done  = out_tuser[5];
    got.unclosed    = out_tuser[6];
    got.end_of_text = out_tuser[7];
    got.run_last    = out_tlast;
    if (due_token_items.size() == 0) begin
      errors++;
      $display("%0t: unexpected token item: expected none, got %s", $time, item_text(got));
      return;
    end
    want = due_token_items.pop_front();
    n_items++;
    if (want.kind !== got.kind || want.value_byte !== got.value_byte ||
        want.has_byte !== got.has_byte || want.token_done !== got.token_done ||
        want.unclosed !== got.unclosed || want.end_of_text !== got.end_of_text ||
        want.run_last !== got.run_last) begin
      errors++;
      $display("%0t: token item mismatch: expected %s, got %s", $time,
               item_text(want), item_text(got));
    end else if (got.token_done) begin
      n_tokens++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lexer();
      due_token_items.delete();
    end else begin
      // compare before predicting so an early item never meets its own prediction
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) tokenize_char(in_tdata, in_tlast);
    end
    fail_count     <= errors;
    pending_items  <= due_token_items.size();
    items_checked  <= n_items;
    tokens_checked <= n_tokens;
  end

endmodule

/* tb/sv/condition_expression_lexer_unit_test.sv */
// ----------------------------------------------------------------------------
// condition_expression_lexer_unit_test
// Streams directed and random expression text into the lexer with random
// gaps and output stalls, including one long output hold-off, while a
// checker tokenizes the same characters and compares every result item.
// ----------------------------------------------------------------------------
module condition_expression_lexer_unit_test;
  import cel_pkg::*;

  localparam int ITEM_TARGET   = 250;    // minimum characters to send
  localparam int CALM_TAIL     = 40;     // last characters sent with no idling
  localparam int HOLD_AT       = 70;     // receiver cycle that starts the long hold
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 12;
  localparam int WATCHDOG_TIME = 100000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] ch
  logic       in_tlast   = 1'b0;    // final_char
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] value_byte
  logic [7:0] out_tuser;            // [3:0] kind, [4] has_byte, [5] token_done,
                                    // [6] unclosed, [7] end_of_text
  logic       out_tlast;            // run_last

  // set once the run enters its idle-free tail
  logic calm = 1'b0;

  int fail_count;
  int pending_items;
  int items_checked;
  int tokens_checked;

  int busy_chars  = 0;   // non-blank characters accepted
  int sent_chars  = 0;
  int expressions = 0;

  logic [7:0] expr_chars[$];

  string op_text [13] = '{"(", ")", "=", "==", "!=", "!", "||", "&&",
                          ">=", ">", "<=", "<", "-A"};
  string word_chars   = "abcxyzXY019_.:$";

  condition_expression_lexer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  cel_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_items  (pending_items),
    .items_checked  (items_checked),
    .tokens_checked (tokens_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one character and hold it until the lexer takes the transaction.
  // A random gap with in_tvalid low may come first, except in the calm tail.
  task automatic send_char(logic [7:0] c, logic last_flag);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_chars++;
    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) busy_chars++;
    if (sent_chars >= ITEM_TARGET - CALM_TAIL) calm <= 1'b1;
  endtask

  // Send the composed text as one expression, flagging its last character.
  task automatic play_expression();
    for (int i = 0; i < expr_chars.size(); i++)
      send_char(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
    expressions++;
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  // Unquoted word: mostly plain characters, with the odd lone | or &,
  // an escaped byte, or any printable character.
  task automatic append_word();
    int len;
    int r;
    len = $urandom_range(1, 4);
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (r < 6) expr_chars.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      else if (r < 7) expr_chars.push_back(($urandom_range(0, 1) != 0) ? CH_PIPE : CH_AMP);
      else if (r < 8) begin
        expr_chars.push_back(CH_BSLASH);
        expr_chars.push_back(8'($urandom_range(0, 255)));
      end else expr_chars.push_back(8'($urandom_range(33, 126)));
    end
  endtask

  // Quoted string or regex with random bytes. Escape the delimiter and the
  // backslash, and sometimes an ordinary byte. Leave it open only when allowed.
  task automatic append_delimited(logic [7:0] delim, bit may_stay_open);
    int len;
    logic [7:0] b;
    expr_chars.push_back(delim);
    len = $urandom_range(0, 5);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      if (b == delim || b == CH_BSLASH || $urandom_range(0, 5) == 0)
        expr_chars.push_back(CH_BSLASH);
      expr_chars.push_back(b);
    end
    if (!(may_stay_open && $urandom_range(0, 2) == 0)) expr_chars.push_back(delim);
  endtask

  // Build one expression of 1 to 6 tokens: mostly well-formed operators,
  // words, strings, regexes and -A paths, with some raw noise bytes.
  task automatic compose_expression();
    int n_tok;
    int pick;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) append_text(op_text[$urandom_range(0, 12)]);
      else if (pick < 11) append_word();
      else if (pick < 13) append_delimited(CH_QUOTE, t == n_tok - 1);
      else if (pick < 15) append_delimited(CH_SLASH, t == n_tok - 1);
      else if (pick < 17) begin
        append_text("-A");
        if ($urandom_range(0, 1) != 0) begin
          if ($urandom_range(0, 1) != 0) expr_chars.push_back(CH_SPACE);
          expr_chars.push_back(CH_SLASH);
          append_word();
        end
      end else begin
        repeat ($urandom_range(1, 3)) expr_chars.push_back(8'($urandom_range(0, 255)));
      end
      // separator: usually a space, now and then another blank, sometimes none
      if ($urandom_range(0, 3) != 0)
        expr_chars.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(9, 13))
                                                         : CH_SPACE);
    end
  endtask

  // Receiver: random stalls, one long hold-off so the lexer backs up and
  // drops in_tready, and no stalls once calm.
  initial begin
    int rx_cycle;
    int n;
    bit hold_done;
    rx_cycle  = 0;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && rx_cycle >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_cycle += HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 3);
        repeat (n) @(posedge clk);
        rx_cycle += n;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      rx_cycle++;
    end
  end

  // Main stimulus and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every operator, each ending and -A followed by a slash word with a
    // trailing backslash.
    append_text("(=!=>=<=)!><||&&-A/");
    expr_chars.push_back(CH_BSLASH);
    play_expression();

    // Lone pipe and lone dash start words, zero byte inside a word,
    // and a regex left open at the end of text.
    append_text("|x -");
    expr_chars.push_back(8'h00);
    expr_chars.push_back(CH_SPACE);
    expr_chars.push_back(CH_SLASH);
    play_expression();

    // Quote left open holding the top byte value.
    expr_chars.push_back(CH_QUOTE);
    expr_chars.push_back(8'hFF);
    play_expression();

    while (sent_chars < ITEM_TARGET) begin
      compose_expression();
      play_expression();
    end
    in_tvalid <= 1'b0;

    // Let the checker count the last transaction, drain, then allow the tail.
    @(posedge clk);
    while (pending_items != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d expressions, %0d characters (%0d non-blank).",
             expressions, sent_chars, busy_chars);
    $display("Checked %0d result items forming %0d tokens.", items_checked, tokens_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #(WATCHDOG_TIME);
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/cel_pkg.sv
sv/cel_queue.sv
sv/cel_front.sv
sv/cel_back.sv
sv/condition_expression_lexer_unit.sv
tb/sv/cel_token_checker.sv
tb/sv/condition_expression_lexer_unit_test.sv
